// ===== rtl/ir_frame_learn_decoder_assert.svh =====
// Assertion macros for the IR frame learning decoder.
`ifndef IR_FRAME_LEARN_DECODER_ASSERT_SVH
`define IR_FRAME_LEARN_DECODER_ASSERT_SVH
`define IRFL_ASSERT_IMPL(label, clk, rst_n, cond, consequence, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consequence)) \
        else $error(msg);
`define IRFL_ASSERT_NEXT(label, clk, rst_n, cond, consequence, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consequence)) \
        else $error(msg);
`endif

// ===== rtl/irfl_pkg.sv =====
// Package with shared types, constants and functions of the IR frame learning decoder.
`default_nettype none
package irfl_pkg;
    localparam int unsigned MaxItems = 128;
    localparam int unsigned CountSat = 1023;
    localparam int unsigned Cap = (MaxItems < CountSat) ? MaxItems : CountSat;
    localparam int unsigned AddrW = $clog2(MaxItems);
    localparam int unsigned CntW = 10;
    localparam int unsigned DurW = 15;
    localparam int unsigned CodeBits = 28;
    localparam int unsigned BitIdxW = 5;
    localparam int unsigned MinFrame = 8;

    localparam logic [1:0] StMatch  = 2'd0;
    localparam logic [1:0] StHeader = 2'd1;
    localparam logic [1:0] StBits   = 2'd2;
    localparam logic [1:0] StNoLib  = 2'd3;

    localparam logic [2:0] BrandA = 3'd0;
    localparam logic [2:0] BrandB = 3'd1;
    localparam logic [2:0] BrandE = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_H0, S_HDR0, S_HDR1, S_RD_START, S_MARK, S_THR, S_THR_CHK,
        S_BIT_RD, S_BIT, S_LIB, S_OUT
    } t_state;

    typedef struct packed {
        logic       rd_h0;
        logic       rd_h1;
        logic       rd_ptr;
        logic       hdr0;
        logic       hdr1;
        logic       clear;
        logic       set_mark;
        logic       learn;
        logic       bit_step;
        logic       lib;
        logic [1:0] fail_status;
        logic       fail;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic hdr_e;
        logic hdr_fail;
        logic hdr1_ok;
        logic thr_done;
        logic ptr_end;
        logic bits_done;
        logic bit_fail;
        logic lib_ok;
    } t_stat;

    function automatic logic in_window(input logic [DurW-1:0] d, input logic [DurW-1:0] t,
                                       input logic [11:0] m);
        logic [16:0] hi;
        logic [16:0] lo;
        hi = {2'b00, t} + {5'd0, m};
        lo = {2'b00, d} + {5'd0, m};
        return ({2'b00, d} < hi) && (lo > {2'b00, t});
    endfunction

    function automatic logic pulse_match(input logic [31:0] it, input logic al,
                                         input logic [11:0] m, input logic [DurW-1:0] mk,
                                         input logic [DurW-1:0] sp);
        return (it[31] == al) && (it[15] != al) && in_window(it[30:16], mk, m)
            && in_window(it[14:0], sp, m);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/irfl_ctrl.sv =====
// Controller state machine of the IR frame learning decoder.
`default_nettype none
`include "ir_frame_learn_decoder_assert.svh"
module irfl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire irfl_pkg::t_stat i_stat,
    output irfl_pkg::t_cmd      o_cmd,
    output logic                o_busy
);
    irfl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irfl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            irfl_pkg::S_IDLE: begin
                if (i_go) n_state = irfl_pkg::S_RD_H0;
            end
            irfl_pkg::S_RD_H0: begin
                o_cmd.rd_h0 = 1'b1;
                o_cmd.clear = 1'b1;
                n_state = irfl_pkg::S_HDR0;
            end
            irfl_pkg::S_HDR0: begin
                o_cmd.hdr0 = 1'b1;
                o_cmd.rd_h1 = 1'b1;
                if (i_stat.hdr_fail) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.fail_status = irfl_pkg::StHeader;
                    n_state = irfl_pkg::S_OUT;
                end else if (i_stat.hdr_e) begin
                    n_state = irfl_pkg::S_HDR1;
                end else begin
                    n_state = irfl_pkg::S_RD_START;
                end
            end
            irfl_pkg::S_HDR1: begin
                if (!i_stat.hdr1_ok) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.fail_status = irfl_pkg::StHeader;
                    n_state = irfl_pkg::S_OUT;
                end else begin
                    o_cmd.hdr1 = 1'b1;
                    n_state = irfl_pkg::S_RD_START;
                end
            end
            irfl_pkg::S_RD_START: begin
                o_cmd.rd_ptr = 1'b1;
                n_state = irfl_pkg::S_MARK;
            end
            irfl_pkg::S_MARK: begin
                o_cmd.set_mark = 1'b1;
                n_state = irfl_pkg::S_THR;
            end
            irfl_pkg::S_THR: begin
                if (i_stat.thr_done) begin
                    n_state = irfl_pkg::S_THR_CHK;
                end else if (i_stat.ptr_end) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.fail_status = irfl_pkg::StBits;
                    n_state = irfl_pkg::S_OUT;
                end else begin
                    o_cmd.learn = 1'b1;
                    o_cmd.rd_ptr = 1'b1;
                end
            end
            irfl_pkg::S_THR_CHK: begin
                o_cmd.rd_h0 = 1'b0;
                n_state = irfl_pkg::S_BIT_RD;
            end
            irfl_pkg::S_BIT_RD: begin
                o_cmd.rd_ptr = 1'b1;
                n_state = irfl_pkg::S_BIT;
            end
            irfl_pkg::S_BIT: begin
                if (i_stat.bits_done) begin
                    n_state = irfl_pkg::S_LIB;
                end else if (i_stat.ptr_end || i_stat.bit_fail) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.fail_status = irfl_pkg::StBits;
                    n_state = irfl_pkg::S_OUT;
                end else begin
                    o_cmd.bit_step = 1'b1;
                    o_cmd.rd_ptr = 1'b1;
                end
            end
            irfl_pkg::S_LIB: begin
                o_cmd.lib = 1'b1;
                if (!i_stat.lib_ok) begin
                    o_cmd.fail = 1'b1;
                    o_cmd.fail_status = irfl_pkg::StNoLib;
                end
                n_state = irfl_pkg::S_OUT;
            end
            irfl_pkg::S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state = irfl_pkg::S_IDLE;
            end
            default: n_state = irfl_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != irfl_pkg::S_IDLE);

    `IRFL_ASSERT_NEXT(a_go_busy, i_clk, i_rst_n, r_state == irfl_pkg::S_IDLE && i_go, o_busy, "go did not start the decode")
    `IRFL_ASSERT_NEXT(a_out_idle, i_clk, i_rst_n, o_cmd.emit, !o_busy, "emit not followed by idle")
    `IRFL_ASSERT_IMPL(a_fail_out, i_clk, i_rst_n, o_cmd.fail && r_state != irfl_pkg::S_LIB, n_state == irfl_pkg::S_OUT, "failure not routed to output")
endmodule
`default_nettype wire

// ===== rtl/irfl_datapath.sv =====
// Datapath of the IR frame learning decoder: item store, learning and bit decode.
`default_nettype none
`include "ir_frame_learn_decoder_assert.svh"
module irfl_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire logic [31:0]     i_item,
    input  wire logic            i_last,
    input  wire logic            i_active_level,
    input  wire logic [11:0]     i_margin_us,
    input  wire logic [14:0]     i_long_space_split_us,
    input  wire irfl_pkg::t_cmd  i_cmd,
    output irfl_pkg::t_stat      o_stat,
    output logic                 o_go,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [2:0]           o_brand,
    output logic [2:0]           o_variant,
    output logic [5:0]           o_library_index,
    output logic [27:0]          o_frame_code,
    output logic [9:0]           o_item_count
);
    localparam int unsigned AW = irfl_pkg::AddrW;
    localparam int unsigned CW = irfl_pkg::CntW;

    logic [31:0] r_mem [irfl_pkg::MaxItems];
    logic [31:0] r_rd;
    logic [CW-1:0] r_seen, n_seen;
    logic [CW-1:0] r_count;
    logic [CW:0]   r_ptr;
    logic [CW-1:0] r_stored;
    logic [CW:0]   r_start;
    logic [14:0]   r_mark, r_one, r_zero;
    logic [27:0]   r_code;
    logic [irfl_pkg::BitIdxW:0] r_bit;
    logic [2:0]    r_brand, r_variant;
    logic [1:0]    r_status;
    logic          r_go;
    logic          r_valid;
    logic [AW-1:0] w_rd_addr;
    logic          w_do_rd;
    logic          w_is_b, w_is_a, w_is_e;
    logic          w_one, w_zero;
    logic [2:0]    w_var;
    logic          w_lib_ok;
    logic          w_b_mark;

    always_comb begin
        n_seen = r_seen;
        if (r_seen < CW'(irfl_pkg::CountSat)) n_seen = r_seen + 1'b1;
    end

    // store the item while below the capacity
    always_ff @(posedge i_clk) begin
        if (i_wr && ({1'b0, r_seen} < (CW+1)'(irfl_pkg::Cap))) begin
            r_mem[r_seen[AW-1:0]] <= i_item;
        end
        if (w_do_rd) r_rd <= r_mem[w_rd_addr];
    end

    always_comb begin
        w_do_rd = i_cmd.rd_h0 || i_cmd.rd_h1 || i_cmd.rd_ptr;
        if (i_cmd.rd_h0) w_rd_addr = '0;
        else if (i_cmd.rd_h1) w_rd_addr = AW'(1);
        else w_rd_addr = r_ptr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_go <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            r_valid <= i_cmd.emit;
            if (i_wr) begin
                if (i_last) begin
                    r_seen <= '0;
                    r_go <= (n_seen >= CW'(irfl_pkg::MinFrame));
                end else begin
                    r_seen <= n_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && i_last) begin
            r_count <= n_seen;
            r_stored <= (n_seen < CW'(irfl_pkg::Cap)) ? n_seen : CW'(irfl_pkg::Cap);
        end
    end

    assign w_is_a = irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us, 15'd9000, 15'd4500);
    assign w_is_b = irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us, 15'd4500, 15'd4500)
        || irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us, 15'd4300, 15'd4300)
        || irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us, 15'd5800, 15'd7300);
    assign w_is_e = irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us, 15'd3000, 15'd3000);
    assign w_one = irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us, r_mark, r_one);
    assign w_zero = irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us, r_mark, r_zero);
    assign w_b_mark = (r_mark < 15'd5000);

    always_comb begin
        w_lib_ok = 1'b1;
        w_var = '0;
        if (r_brand == irfl_pkg::BrandA) begin
            if (r_count == CW'(70) && r_code == 28'h0200a59) w_var = 3'd1;
            else if (r_count == CW'(36) && r_code == 28'h0200a59) w_var = 3'd3;
            else w_lib_ok = 1'b0;
        end else if (r_brand == irfl_pkg::BrandB) begin
            if (w_b_mark) begin
                if (r_code == 28'h6f9b24d) w_var = 3'd0;
                else if (r_code == 28'h0200a59) w_var = 3'd1;
                else w_lib_ok = 1'b0;
            end else begin
                if (r_code == 28'h96620df) w_var = 3'd3;
                else if (r_code == 28'ha65d02f) w_var = 3'd4;
                else w_lib_ok = 1'b0;
            end
        end else begin
            if (r_code == 28'h0003565) w_var = 3'd0;
            else if (r_code == 28'hcd28f70) w_var = 3'd1;
            else if (r_code == 28'h0008565) w_var = 3'd2;
            else if (r_code == 28'h0073565) w_var = 3'd4;
            else w_lib_ok = 1'b0;
        end
    end

    assign o_stat.hdr_e = !w_is_a && !w_is_b && w_is_e;
    assign o_stat.hdr_fail = !w_is_a && !w_is_b && !w_is_e;
    assign o_stat.hdr1_ok = irfl_pkg::pulse_match(r_rd, i_active_level, i_margin_us,
                                                  15'd3000, 15'd4500);
    assign o_stat.thr_done = (r_one != '0) && (r_zero != '0);
    assign o_stat.ptr_end = ({1'b0, r_ptr} > {2'b00, r_stored});
    assign o_stat.bits_done = (r_bit == (irfl_pkg::BitIdxW+1)'(irfl_pkg::CodeBits));
    assign o_stat.bit_fail = !w_one && !w_zero;
    assign o_stat.lib_ok = w_lib_ok;

    // r_ptr is the address of the next read; r_rd holds the item at r_ptr - 1
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mark <= '0;
            r_one <= '0;
            r_zero <= '0;
            r_code <= '0;
            r_bit <= '0;
            r_brand <= '0;
            r_variant <= '0;
            r_status <= irfl_pkg::StMatch;
            r_start <= (CW+1)'(1);
            r_ptr <= (CW+1)'(1);
        end
        if (i_cmd.hdr0) begin
            r_brand <= w_is_a ? irfl_pkg::BrandA : (w_is_b ? irfl_pkg::BrandB : irfl_pkg::BrandE);
        end
        if (i_cmd.hdr1) begin
            r_start <= (CW+1)'(2);
            r_ptr <= (CW+1)'(2);
        end
        if (i_cmd.rd_ptr) r_ptr <= r_ptr + 1'b1;
        if (i_cmd.set_mark) begin
            if (r_rd[31] == i_active_level) r_mark <= r_rd[30:16];
        end
        if (i_cmd.learn) begin
            if (r_rd[14:0] > i_long_space_split_us) r_one <= r_rd[14:0];
            else r_zero <= r_rd[14:0];
        end
        if (i_cmd.hdr0 == 1'b0 && i_cmd.rd_h0 == 1'b0 && i_cmd.fail == 1'b0
            && i_cmd.learn == 1'b0 && i_cmd.bit_step == 1'b0 && i_cmd.rd_ptr == 1'b0
            && i_cmd.set_mark == 1'b0 && i_cmd.lib == 1'b0 && i_cmd.emit == 1'b0
            && i_cmd.hdr1 == 1'b0 && i_cmd.clear == 1'b0 && o_stat.thr_done) begin
            r_ptr <= r_start;
        end
        if (i_cmd.bit_step) begin
            if (w_one) r_code <= r_code | (28'd1 << r_bit[irfl_pkg::BitIdxW-1:0]);
            r_bit <= r_bit + 1'b1;
        end
        if (i_cmd.lib) r_variant <= w_var;
        if (i_cmd.fail) r_status <= i_cmd.fail_status;
    end

    assign o_go = r_go;
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_brand = (r_status == irfl_pkg::StHeader) ? 3'd0 : r_brand;
    assign o_variant = (r_status == irfl_pkg::StMatch) ? r_variant : 3'd0;
    assign o_library_index = (r_status == irfl_pkg::StMatch)
        ? 6'(({3'd0, r_brand} * 6'd5) + {3'd0, r_variant}) : 6'd0;
    assign o_frame_code = (r_status == irfl_pkg::StMatch || r_status == irfl_pkg::StNoLib)
        ? r_code : 28'd0;
    assign o_item_count = r_count;

    `IRFL_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_wr && i_last, r_seen == '0, "count not cleared after last item")
    `IRFL_ASSERT_IMPL(a_bit_bound, i_clk, i_rst_n, i_cmd.bit_step, r_bit < (irfl_pkg::BitIdxW+1)'(irfl_pkg::CodeBits), "bit index overran")
    `IRFL_ASSERT_NEXT(a_valid_one, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
endmodule
`default_nettype wire

// ===== rtl/ir_frame_learn_decoder.sv =====
// Top level of the IR frame learning decoder.
// Items are taken one per cycle while busy is low; busy rises in the cycle after the last item
// of a frame of 8 or more items; shorter frames start no decode. A decoded frame's o_valid
// follows its k header items (1 or 2) and L items for both spaces (at most S - k of S stored).
// Result strobe o_valid lasts one cycle and cannot be stalled; busy falls in that cycle.
// Synchronous active-low reset clears count, controller and configuration to defaults.
`default_nettype none
module ir_frame_learn_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data,
    input  wire logic        i_first_level,
    input  wire logic [14:0] i_first_duration_us,
    input  wire logic        i_second_level,
    input  wire logic [14:0] i_second_duration_us,
    input  wire logic        i_last_item,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [2:0]       o_brand,
    output logic [2:0]       o_variant,
    output logic [5:0]       o_library_index,
    output logic [27:0]      o_frame_code,
    output logic [9:0]       o_item_count
);
    localparam logic [1:0] RegActive = 2'd0;
    localparam logic [1:0] RegMargin = 2'd1;
    localparam logic [1:0] RegSplit  = 2'd2;

    logic            r_active_level;
    logic [11:0]     r_margin_us;
    logic [14:0]     r_long_space_split_us;
    irfl_pkg::t_cmd  w_cmd;
    irfl_pkg::t_stat w_stat;
    logic            w_go, w_busy, w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= 1'b0;
            r_margin_us <= 12'd200;
            r_long_space_split_us <= 15'd1500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegActive: r_active_level <= i_cfg_data[0];
                RegMargin: r_margin_us <= i_cfg_data[11:0];
                RegSplit: r_long_space_split_us <= i_cfg_data;
                default: r_active_level <= r_active_level;
            endcase
        end
    end

    // hold off requests while a frame decode is pending
    assign busy = w_busy || w_go;
    assign w_wr = start && !busy;

    irfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    irfl_datapath u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_wr                  (w_wr),
        .i_item                ({i_first_level, i_first_duration_us,
                                 i_second_level, i_second_duration_us}),
        .i_last                (i_last_item),
        .i_active_level        (r_active_level),
        .i_margin_us           (r_margin_us),
        .i_long_space_split_us (r_long_space_split_us),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .o_go                  (w_go),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_brand               (o_brand),
        .o_variant             (o_variant),
        .o_library_index       (o_library_index),
        .o_frame_code          (o_frame_code),
        .o_item_count          (o_item_count)
    );
endmodule
`default_nettype wire
